@@ src/pmtc_pkg.sv @@
// package for the point mass table centroid block
// field widths, payload structs, operation and status codes
`timescale 1ns / 1ps
package pmtc_pkg;
  localparam int DEPTH_DEF      = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int MASS_BITS_DEF  = 16;
  localparam int IDX_BITS       = 6;
  localparam int CNT_BITS       = 7;

  localparam logic [1:0] FUNC_PUSH     = 2'd0;
  localparam logic [1:0] FUNC_COMPACT  = 2'd1;
  localparam logic [1:0] FUNC_READ     = 2'd2;
  localparam logic [1:0] FUNC_CENTROID = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [COORD_BITS_DEF-1:0] point_x;
    logic signed [COORD_BITS_DEF-1:0] point_y;
    logic [MASS_BITS_DEF-1:0]     point_mass;
    logic [IDX_BITS-1:0]          index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0] out_x;
    logic signed [COORD_BITS_DEF-1:0] out_y;
    logic [MASS_BITS_DEF-1:0]     out_mass;
    logic [CNT_BITS-1:0]          count;
    logic [1:0]                   status;
  } out_item_t;
endpackage

@@ src/pmtc_ram.sv @@
// generic ram with one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
module pmtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/point_mass_table_centroid.sv @@
// point mass table centroid, top level
// uses pmtc_pkg and pmtc_ram
`timescale 1ns / 1ps
// Usage: one input transfer (in_valid/in_stall, in_item) runs one operation
// and gives exactly one result transfer (out_valid/out_stall, out_item).
// The block takes one item at a time; in_stall is high from acceptance until
// the result has been placed in the output register.
// Centroid runs the shared one-bit-per-cycle restoring divider for x then
// y; compact walks the table entry by entry through the ram, reading each
// entry and writing it back only if its mass is nonzero.
// A waiting result holds in out_item until out_stall drops; a new item may
// be accepted while the result waits, and its result waits behind it.
// Reset (rst_n low, synchronous) empties the table and clears the sums;
// table contents are undefined until pushed.
module point_mass_table_centroid #(
  parameter int DEPTH = pmtc_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pmtc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pmtc_pkg::out_item_t out_item
);
  localparam int COORD_BITS = pmtc_pkg::COORD_BITS_DEF;
  localparam int MASS_BITS  = pmtc_pkg::MASS_BITS_DEF;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = 2 * COORD_BITS + MASS_BITS;
  localparam int SUM_BITS = COORD_BITS + MASS_BITS + CW + 1;
  localparam int MSUM_BITS = MASS_BITS + CW;
  localparam int QCW = $clog2(SUM_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDW  = 3'd1;
  localparam logic [2:0] S_CRD  = 3'd2;
  localparam logic [2:0] S_CWR  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [SUM_BITS-1:0] smx_r, smx_nxt, smy_r, smy_nxt;
  logic [MSUM_BITS-1:0] sm_r, sm_nxt;
  logic [CW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [SUM_BITS-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [QCW-1:0] bit_r, bit_nxt;
  logic axis_r, axis_nxt, neg_r, neg_nxt;
  logic signed [COORD_BITS-1:0] qx_r, qx_nxt;
  logic [1:0] st_r, st_nxt;
  logic signed [COORD_BITS-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [MASS_BITS-1:0] rm_r, rm_nxt;
  logic ov_r, ov_nxt;
  logic oi_valid_r, oi_valid_nxt;
  pmtc_pkg::out_item_t oi_r, oi_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [PW-1:0] wdata, rdata;

  pmtc_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic signed [COORD_BITS-1:0] ix, iy, dx, dy;
  logic [MASS_BITS-1:0] im, dm;
  logic signed [COORD_BITS+MASS_BITS:0] prod_x, prod_y;
  logic signed [SUM_BITS-1:0] px, py;
  logic [SUM_BITS:0] trial;
  logic [SUM_BITS-1:0] qs;
  logic res_fire;

  assign ix = COORD_BITS'(in_item.point_x);
  assign iy = COORD_BITS'(in_item.point_y);
  assign im = MASS_BITS'(in_item.point_mass);
  assign dx = rdata[PW-1 -: COORD_BITS];
  assign dy = rdata[MASS_BITS +: COORD_BITS];
  assign dm = rdata[MASS_BITS-1:0];
  assign prod_x = ix * $signed({1'b0, im});
  assign prod_y = iy * $signed({1'b0, im});
  assign px = SUM_BITS'(prod_x);
  assign py = SUM_BITS'(prod_y);
  assign trial = {rem_r, quo_r[SUM_BITS-1]} - {1'b0, SUM_BITS'(sm_r)};
  assign qs = neg_r ? SUM_BITS'(-quo_r) : quo_r;

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign out_valid = oi_valid_r;
  assign out_item = oi_r;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r;
    smx_nxt = smx_r; smy_nxt = smy_r; sm_nxt = sm_r;
    rp_nxt = rp_r; wp_nxt = wp_r; rem_nxt = rem_r; quo_nxt = quo_r;
    bit_nxt = bit_r; axis_nxt = axis_r; neg_nxt = neg_r; qx_nxt = qx_r;
    st_nxt = st_r; rx_nxt = rx_r; ry_nxt = ry_r; rm_nxt = rm_r;
    ov_nxt = ov_r; oi_nxt = oi_r; oi_valid_nxt = oi_valid_r;
    we = 1'b0; waddr = AW'(cnt_r); wdata = {ix, iy, im};
    raddr = AW'(in_item.index);
    res_fire = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          st_nxt = pmtc_pkg::ST_OK;
          rx_nxt = '0; ry_nxt = '0; rm_nxt = '0;
          case (in_item.func)
            pmtc_pkg::FUNC_PUSH: begin
              if (cnt_r >= CW'(DEPTH)) begin
                st_nxt = pmtc_pkg::ST_FULL;
              end else begin
                we = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                smx_nxt = smx_r + px; smy_nxt = smy_r + py;
                sm_nxt = sm_r + MSUM_BITS'(im);
              end
              state_nxt = S_OUT;
            end
            pmtc_pkg::FUNC_COMPACT: begin
              rp_nxt = '0; wp_nxt = '0;
              state_nxt = S_CRD;
            end
            pmtc_pkg::FUNC_READ: begin
              if (CW'(in_item.index) >= cnt_r || 32'(in_item.index) >= DEPTH) begin
                st_nxt = pmtc_pkg::ST_RANGE;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_RDW;
              end
            end
            default: begin
              if (sm_r == '0) begin
                st_nxt = pmtc_pkg::ST_ZERO;
                state_nxt = S_OUT;
              end else begin
                axis_nxt = 1'b0;
                neg_nxt = smx_r[SUM_BITS-1];
                quo_nxt = smx_r[SUM_BITS-1] ? SUM_BITS'(-smx_r) : SUM_BITS'(smx_r);
                rem_nxt = '0; bit_nxt = '0;
                state_nxt = S_DIV;
              end
            end
          endcase
        end
      end
      S_RDW: begin
        rx_nxt = dx; ry_nxt = dy; rm_nxt = dm;
        state_nxt = S_OUT;
      end
      S_CRD: begin
        // issue read of the next entry, or finish
        raddr = AW'(rp_r);
        if (rp_r >= cnt_r) begin
          cnt_nxt = wp_r;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        waddr = AW'(wp_r); wdata = rdata;
        if (dm != '0) begin
          we = 1'b1; wp_nxt = wp_r + 1'b1;
        end
        rp_nxt = rp_r + 1'b1;
        state_nxt = S_CRD;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!trial[SUM_BITS]) begin
          rem_nxt = trial[SUM_BITS-1:0];
          quo_nxt = {quo_r[SUM_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[SUM_BITS-2:0], quo_r[SUM_BITS-1]};
          quo_nxt = {quo_r[SUM_BITS-2:0], 1'b0};
        end
        bit_nxt = bit_r + 1'b1;
        if (bit_r == QCW'(SUM_BITS)) begin
          rem_nxt = rem_r; quo_nxt = quo_r;
          if (!axis_r) begin
            qx_nxt = COORD_BITS'(qs);
            axis_nxt = 1'b1;
            neg_nxt = smy_r[SUM_BITS-1];
            quo_nxt = smy_r[SUM_BITS-1] ? SUM_BITS'(-smy_r) : SUM_BITS'(smy_r);
            rem_nxt = '0; bit_nxt = '0;
          end else begin
            rx_nxt = qx_r; ry_nxt = COORD_BITS'(qs);
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        res_fire = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (oi_valid_r && !out_stall) oi_valid_nxt = 1'b0;
    // result waits in a hold register if the output is still occupied
    if (ov_r && !oi_valid_nxt) begin
      oi_valid_nxt = 1'b1; ov_nxt = 1'b0;
      oi_nxt.out_x = rx_r; oi_nxt.out_y = ry_r; oi_nxt.out_mass = rm_r;
      oi_nxt.count = pmtc_pkg::CNT_BITS'(cnt_r); oi_nxt.status = st_r;
    end
    if (res_fire) begin
      state_nxt = S_IDLE;
      if (!oi_valid_nxt) begin
        oi_valid_nxt = 1'b1;
        oi_nxt.out_x = rx_r; oi_nxt.out_y = ry_r; oi_nxt.out_mass = rm_r;
        oi_nxt.count = pmtc_pkg::CNT_BITS'(cnt_r); oi_nxt.status = st_r;
      end else begin
        ov_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0;
      smx_r <= '0; smy_r <= '0; sm_r <= '0;
      ov_r <= 1'b0; oi_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt;
      smx_r <= smx_nxt; smy_r <= smy_nxt; sm_r <= sm_nxt;
      ov_r <= ov_nxt; oi_valid_r <= oi_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r <= rp_nxt; wp_r <= wp_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    bit_r <= bit_nxt; axis_r <= axis_nxt; neg_r <= neg_nxt; qx_r <= qx_nxt;
    st_r <= st_nxt; rx_r <= rx_nxt; ry_r <= ry_nxt; rm_r <= rm_nxt;
    oi_r <= oi_nxt;
  end
endmodule
